// ===== rtl/core/gzhp_pkg.sv =====
// gzip header parser: shared types and constants
`default_nettype none

package gzhp_pkg;

    // fixed part of the member header
    localparam int unsigned FIXED_LEN = 10;

    localparam logic [7:0] MAGIC_ID1          = 8'h1F;
    localparam logic [7:0] MAGIC_ID2          = 8'h8B;
    localparam logic [7:0] METHOD_DEFLATE     = 8'h08;
    localparam logic [7:0] FLAG_RESERVED_MASK = 8'hE0;

    // flag bit positions
    localparam int unsigned FLG_FHCRC    = 1;
    localparam int unsigned FLG_FEXTRA   = 2;
    localparam int unsigned FLG_FNAME    = 3;
    localparam int unsigned FLG_FCOMMENT = 4;

    // saturation point of the text length counter
    localparam logic [16:0] TEXT_MAX = 17'h1FFFF;

    // reflected CRC-32 polynomial
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    // register file
    localparam logic [15:0] MAX_FIELD_RESET   = 16'd1024;
    localparam logic        REG_MAX_FIELD_LEN = 1'b0;

    typedef enum logic [2:0] {
        PH_FIXED   = 3'd0,
        PH_XLEN    = 3'd1,
        PH_EXTRA   = 3'd2,
        PH_NAME    = 3'd3,
        PH_COMMENT = 3'd4,
        PH_HCRC    = 3'd5,
        PH_DONE    = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_CHECKSUM = 2'd2,
        ST_INTERNAL = 2'd3
    } status_t;

    typedef struct packed {
        status_t status;
        logic    header_done;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/gzhp_crc32.sv =====
// gzip header parser: bytewise CRC-32 update (reflected, pre and post inverted)
`default_nettype none

module gzhp_crc32
    import gzhp_pkg::*;
(
    input  wire logic [31:0] crc_in,
    input  wire logic [7:0]  data,
    output logic      [31:0] crc_out
);

    logic [31:0] c;

    // eight shift and conditional xor steps, one per data bit
    always_comb begin
        c = (~crc_in) ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        crc_out = ~c;
    end

endmodule

`default_nettype wire

// ===== rtl/core/gzhp_parser.sv =====
// gzip header parser: header state machine, field counters and running crc
`default_nettype none

module gzhp_parser
    import gzhp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step_en,
    input  wire logic [7:0]  hdr_byte,
    input  wire logic        restart,
    input  wire logic [15:0] max_field_length,
    output result_t          result
);

    phase_t      phase_reg, phase_next, phase_cur;
    logic [3:0]  fixed_count_reg, fixed_count_next, fixed_count_cur;
    logic [7:0]  flag_byte_reg, flag_byte_next, flag_byte_cur;
    logic [15:0] extra_length_reg, extra_length_next, extra_length_cur;
    logic [1:0]  extra_length_count_reg, extra_length_count_next, extra_length_count_cur;
    logic [15:0] extra_skipped_reg, extra_skipped_next, extra_skipped_cur;
    logic [16:0] text_length_reg, text_length_next, text_length_cur;
    logic [7:0]  check_low_byte_reg, check_low_byte_next, check_low_byte_cur;
    logic [1:0]  check_count_reg, check_count_next, check_count_cur;
    logic [31:0] running_crc_reg, running_crc_next, running_crc_cur;

    logic [31:0] crc_upd;
    logic [3:0]  fc_inc;
    logic        fixed_bad;
    logic [15:0] xlen_new;
    logic [1:0]  xlc_inc;
    logic [15:0] skip_inc;
    logic [16:0] text_inc;
    logic        text_over;
    logic        hcrc_match;
    phase_t      ph_after_extra, ph_after_name, ph_after_comment;
    status_t     status;

    function automatic phase_t after_extra(input logic [7:0] f);
        phase_t p;
        if (f[FLG_FNAME]) begin
            p = PH_NAME;
        end else if (f[FLG_FCOMMENT]) begin
            p = PH_COMMENT;
        end else if (f[FLG_FHCRC]) begin
            p = PH_HCRC;
        end else begin
            p = PH_DONE;
        end
        return p;
    endfunction

    // restart clears the state seen by this beat
    assign phase_cur              = restart ? PH_FIXED : phase_reg;
    assign fixed_count_cur        = restart ? '0 : fixed_count_reg;
    assign flag_byte_cur          = restart ? '0 : flag_byte_reg;
    assign extra_length_cur       = restart ? '0 : extra_length_reg;
    assign extra_length_count_cur = restart ? '0 : extra_length_count_reg;
    assign extra_skipped_cur      = restart ? '0 : extra_skipped_reg;
    assign text_length_cur        = restart ? '0 : text_length_reg;
    assign check_low_byte_cur     = restart ? '0 : check_low_byte_reg;
    assign check_count_cur        = restart ? '0 : check_count_reg;
    assign running_crc_cur        = restart ? '0 : running_crc_reg;

    gzhp_crc32 u_crc (
        .crc_in  (running_crc_cur),
        .data    (hdr_byte),
        .crc_out (crc_upd)
    );

    // fixed header checks
    assign fc_inc    = fixed_count_cur + 4'd1;
    assign fixed_bad = ((fc_inc == 4'd1) && (hdr_byte != MAGIC_ID1))
                    || ((fc_inc == 4'd2) && (hdr_byte != MAGIC_ID2))
                    || ((fc_inc == 4'd3) && (hdr_byte != METHOD_DEFLATE))
                    || ((fc_inc == 4'd4) && ((hdr_byte & FLAG_RESERVED_MASK) != 8'd0));

    // extra field length, little endian
    assign xlen_new = (extra_length_count_cur == 2'd0)
                    ? (extra_length_cur | {8'd0, hdr_byte})
                    : (extra_length_cur | {hdr_byte, 8'd0});
    assign xlc_inc  = extra_length_count_cur + 2'd1;
    assign skip_inc = extra_skipped_cur + 16'd1;

    // name and comment length, saturating
    assign text_inc  = (text_length_cur < TEXT_MAX) ? (text_length_cur + 17'd1)
                                                    : text_length_cur;
    assign text_over = text_inc > {1'b0, max_field_length};

    // header crc is the low half of the running crc
    assign hcrc_match = {hdr_byte, check_low_byte_cur} == running_crc_cur[15:0];

    assign ph_after_extra   = after_extra(flag_byte_cur);
    assign ph_after_name    = flag_byte_cur[FLG_FCOMMENT] ? PH_COMMENT
                            : (flag_byte_cur[FLG_FHCRC] ? PH_HCRC : PH_DONE);
    assign ph_after_comment = flag_byte_cur[FLG_FHCRC] ? PH_HCRC : PH_DONE;

    // next state
    always_comb begin
        phase_next              = phase_cur;
        fixed_count_next        = fixed_count_cur;
        flag_byte_next          = flag_byte_cur;
        extra_length_next       = extra_length_cur;
        extra_length_count_next = extra_length_count_cur;
        extra_skipped_next      = extra_skipped_cur;
        text_length_next        = text_length_cur;
        check_low_byte_next     = check_low_byte_cur;
        check_count_next        = check_count_cur;
        running_crc_next        = (phase_cur != PH_HCRC) ? crc_upd : running_crc_cur;
        case (phase_cur)
            PH_FIXED: begin
                fixed_count_next = fc_inc;
                if (!fixed_bad) begin
                    if (fc_inc == 4'd4) begin
                        flag_byte_next = hdr_byte;
                    end
                    if (fc_inc >= 4'(FIXED_LEN)) begin
                        phase_next = flag_byte_cur[FLG_FEXTRA] ? PH_XLEN : ph_after_extra;
                    end
                end
            end
            PH_XLEN: begin
                extra_length_next       = xlen_new;
                extra_length_count_next = xlc_inc;
                if (xlc_inc >= 2'd2) begin
                    phase_next = (xlen_new != 16'd0) ? PH_EXTRA : ph_after_extra;
                end
            end
            PH_EXTRA: begin
                extra_skipped_next = skip_inc;
                if (skip_inc >= extra_length_cur) begin
                    phase_next = ph_after_extra;
                end
            end
            PH_NAME: begin
                if (hdr_byte != 8'd0) begin
                    text_length_next = text_inc;
                end else begin
                    text_length_next = '0;
                    phase_next       = ph_after_name;
                end
            end
            PH_COMMENT: begin
                if (hdr_byte != 8'd0) begin
                    text_length_next = text_inc;
                end else begin
                    text_length_next = '0;
                    phase_next       = ph_after_comment;
                end
            end
            PH_HCRC: begin
                if (check_count_cur == 2'd0) begin
                    check_low_byte_next = hdr_byte;
                    check_count_next    = 2'd1;
                end else if (check_count_cur == 2'd1) begin
                    check_count_next = 2'd2;
                    if (hcrc_match) begin
                        phase_next = PH_DONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // beat status
    always_comb begin
        case (phase_cur)
            PH_FIXED: begin
                status = fixed_bad ? ST_INVALID : ST_OK;
            end
            PH_XLEN, PH_EXTRA: begin
                status = ST_OK;
            end
            PH_NAME, PH_COMMENT: begin
                status = ((hdr_byte != 8'd0) && text_over) ? ST_INVALID : ST_OK;
            end
            PH_HCRC: begin
                if (check_count_cur >= 2'd2) begin
                    status = ST_CHECKSUM;
                end else if (check_count_cur == 2'd0) begin
                    status = ST_OK;
                end else begin
                    status = hcrc_match ? ST_OK : ST_CHECKSUM;
                end
            end
            default: begin
                status = ST_INTERNAL;
            end
        endcase
        result.status      = status;
        result.header_done = (status == ST_OK) && (phase_next == PH_DONE);
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg              <= PH_FIXED;
            fixed_count_reg        <= '0;
            flag_byte_reg          <= '0;
            extra_length_reg       <= '0;
            extra_length_count_reg <= '0;
            extra_skipped_reg      <= '0;
            text_length_reg        <= '0;
            check_low_byte_reg     <= '0;
            check_count_reg        <= '0;
            running_crc_reg        <= '0;
        end else if (step_en) begin
            phase_reg              <= phase_next;
            fixed_count_reg        <= fixed_count_next;
            flag_byte_reg          <= flag_byte_next;
            extra_length_reg       <= extra_length_next;
            extra_length_count_reg <= extra_length_count_next;
            extra_skipped_reg      <= extra_skipped_next;
            text_length_reg        <= text_length_next;
            check_low_byte_reg     <= check_low_byte_next;
            check_count_reg        <= check_count_next;
            running_crc_reg        <= running_crc_next;
        end
    end

    // done is sticky until restart
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && !restart && (phase_reg == PH_DONE)) |=> (phase_reg == PH_DONE))
        else $error("parser left done phase without restart");

    // a failed header crc keeps failing
    a_hcrc_stuck: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && !restart && (phase_reg == PH_HCRC) && (check_count_reg == 2'd2))
        |-> (result.status == ST_CHECKSUM))
        else $error("header crc mismatch not repeated");

    // crc is not advanced by the header crc bytes
    a_crc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && !restart && (phase_reg == PH_HCRC))
        |=> (running_crc_reg == $past(running_crc_reg)))
        else $error("running crc changed in header crc phase");

endmodule

`default_nettype wire

// ===== rtl/core/gzip_header_parser_top.sv =====
// gzip header parser: top level with input register, result register and APB registers
//
//  channel   | ports                                   | direction | role
//  ----------+-----------------------------------------+-----------+------------------------
//  input     | s_valid s_ready s_hdr_byte s_restart    | in        | one header byte per beat
//  result    | m_valid m_ready m_status m_header_done  | out       | one result per input beat
//  config    | psel penable pwrite paddr pwdata prdata | in/out    | max_field_length at 0x0
//
//  one beat per cycle while results are taken; a byte is registered at input, then at result
//  the parser state and crc-32 byte update sit between the input and result registers
//  aresetn is synchronous: state clears, max_field_length returns to 1024
//  a stalled result holds the result register; the input register then fills and s_ready drops
`default_nettype none

module gzip_header_parser_top
    import gzhp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_hdr_byte,
    input  wire logic        s_restart,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic             m_header_done,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_restart_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_result_reg;
    result_t     step_result;
    logic        advance;
    logic        s_take;
    logic [15:0] max_field_length_reg, max_field_length_next;
    logic        reg_sel;

    // handshake control
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg    <= s_hdr_byte;
            in_restart_reg <= s_restart;
        end
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    gzhp_parser u_parser (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step_en          (advance),
        .hdr_byte         (in_byte_reg),
        .restart          (in_restart_reg),
        .max_field_length (max_field_length_reg),
        .result           (step_result)
    );

    assign m_valid       = out_valid_reg;
    assign m_status      = out_result_reg.status;
    assign m_header_done = out_result_reg.header_done;

    // configuration register
    assign reg_sel = paddr[2] == REG_MAX_FIELD_LEN;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {16'd0, max_field_length_reg} : 32'd0;

    always_comb begin
        max_field_length_next = max_field_length_reg;
        if (psel && penable && pwrite && reg_sel) begin
            max_field_length_next = pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_field_length_reg <= MAX_FIELD_RESET;
        end else begin
            max_field_length_reg <= max_field_length_next;
        end
    end

    // every byte that enters the parser yields a result next cycle
    a_step_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed beat produced no result");

    // an empty input register always takes a beat
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but not ready");

    // done is only flagged on a clean beat
    a_done_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_header_done) |-> (m_status == ST_OK))
        else $error("header done with error status");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench for the gzip header parser: byte-level predictor, scoreboard and stream drivers
module testbench
    import gzhp_pkg::*;
();

    localparam logic [2:0] MAX_LEN_ADDR  = 3'(4 * REG_MAX_FIELD_LEN);
    localparam logic [7:0] FLAGS_DEFINED = ~FLAG_RESERVED_MASK;
    localparam int         REPORT_LIMIT  = 100;

    // bytewise reflected crc-32, init and final inversion folded in
    function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        int          i;
        c = ~crc ^ {24'h0, b};
        for (i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return ~c;
    endfunction

    // parser predictor and store of expected results
    class header_scoreboard;
        int          errors;
        logic [15:0] max_len;
        result_t     expected_q[$];
        phase_t      phase;
        logic [3:0]  fixed_cnt;
        logic [7:0]  flags;
        logic [15:0] xlen;
        logic [1:0]  xlen_cnt;
        logic [15:0] xskip;
        logic [16:0] text_len;
        logic [7:0]  crc_lo;
        logic [1:0]  crc_cnt;
        logic [31:0] crc;

        function new();
            errors  = 0;
            max_len = MAX_FIELD_RESET;
            clear();
        endfunction

        function void clear();
            phase     = PH_FIXED;
            fixed_cnt = '0;
            flags     = '0;
            xlen      = '0;
            xlen_cnt  = '0;
            xskip     = '0;
            text_len  = '0;
            crc_lo    = '0;
            crc_cnt   = '0;
            crc       = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function phase_t after_extra();
            if (flags[FLG_FNAME]) return PH_NAME;
            if (flags[FLG_FCOMMENT]) return PH_COMMENT;
            if (flags[FLG_FHCRC]) return PH_HCRC;
            return PH_DONE;
        endfunction

        function phase_t after_name();
            if (flags[FLG_FCOMMENT]) return PH_COMMENT;
            if (flags[FLG_FHCRC]) return PH_HCRC;
            return PH_DONE;
        endfunction

        // name or comment byte, nul ends the field
        function status_t text_beat(logic [7:0] b, phase_t nxt);
            if (b != 8'h00) begin
                if (text_len < TEXT_MAX) text_len = text_len + 17'd1;
                return (text_len > {1'b0, max_len}) ? ST_INVALID : ST_OK;
            end
            text_len = '0;
            phase    = nxt;
            return ST_OK;
        endfunction

        // one header byte through the parser
        function status_t advance(logic [7:0] b);
            if (phase != PH_HCRC) crc = crc32_byte(crc, b);
            case (phase)
                PH_FIXED: begin
                    fixed_cnt = fixed_cnt + 4'd1;
                    if (fixed_cnt == 4'd1 && b != MAGIC_ID1) return ST_INVALID;
                    if (fixed_cnt == 4'd2 && b != MAGIC_ID2) return ST_INVALID;
                    if (fixed_cnt == 4'd3 && b != METHOD_DEFLATE) return ST_INVALID;
                    if (fixed_cnt == 4'd4) begin
                        if ((b & FLAG_RESERVED_MASK) != 8'h00) return ST_INVALID;
                        flags = b;
                    end
                    if (fixed_cnt < FIXED_LEN) return ST_OK;
                    phase = flags[FLG_FEXTRA] ? PH_XLEN : after_extra();
                    return ST_OK;
                end
                PH_XLEN: begin
                    if (xlen_cnt == 2'd0) xlen = xlen | {8'h00, b};
                    else xlen = xlen | {b, 8'h00};
                    xlen_cnt = xlen_cnt + 2'd1;
                    if (xlen_cnt < 2'd2) return ST_OK;
                    phase = (xlen > 16'd0) ? PH_EXTRA : after_extra();
                    return ST_OK;
                end
                PH_EXTRA: begin
                    xskip = xskip + 16'd1;
                    if (xskip < xlen) return ST_OK;
                    phase = after_extra();
                    return ST_OK;
                end
                PH_NAME: return text_beat(b, after_name());
                PH_COMMENT: return text_beat(b, flags[FLG_FHCRC] ? PH_HCRC : PH_DONE);
                PH_HCRC: begin
                    if (crc_cnt >= 2'd2) return ST_CHECKSUM;
                    if (crc_cnt == 2'd0) begin
                        crc_lo  = b;
                        crc_cnt = 2'd1;
                        return ST_OK;
                    end
                    crc_cnt = 2'd2;
                    if ({b, crc_lo} != crc[15:0]) return ST_CHECKSUM;
                    phase = PH_DONE;
                    return ST_OK;
                end
                default: return ST_INTERNAL;
            endcase
        endfunction

        // accepted input beat
        function void note_beat(logic [7:0] b, logic restart);
            result_t exp;
            if (restart) clear();
            exp.status      = advance(b);
            exp.header_done = (exp.status == ST_OK && phase == PH_DONE);
            expected_q.push_back(exp);
        endfunction

        function void flag_mismatch(string field, int exp_val, int act_val);
            errors++;
            if (errors <= REPORT_LIMIT)
                $error("%s mismatch: expected %0d, got %0d", field, exp_val, act_val);
        endfunction

        // accepted result beat against the oldest expectation
        function void check_beat(logic [1:0] status, logic header_done);
            result_t exp;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $error("result beat with nothing expected: status %0d header_done %0d",
                           status, header_done);
                return;
            end
            exp = expected_q.pop_front();
            if (status !== exp.status) flag_mismatch("status", exp.status, status);
            if (header_done !== exp.header_done)
                flag_mismatch("header_done", exp.header_done, header_done);
        endfunction
    endclass

    typedef struct {
        logic [7:0] b;
        logic       restart;
    } beat_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_hdr_byte    = 8'h00;
    logic        s_restart     = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [1:0]  m_status;
    logic        m_header_done;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = 3'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    header_scoreboard sb = new();
    beat_t            burst_q[$];
    int               idle_pct  = 0;
    int               stall_pct = 0;

    gzip_header_parser_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_hdr_byte    (s_hdr_byte),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_header_done (m_header_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 aclk = ~aclk;

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // beats seen on both channels; results checked before new inputs are noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_beat(m_status, m_header_done);
            if (s_valid && s_ready) sb.note_beat(s_hdr_byte, s_restart);
        end
    end

    // stream building
    function automatic void push_beat(logic [7:0] b, logic restart);
        beat_t bt;
        bt.b       = b;
        bt.restart = restart;
        burst_q.push_back(bt);
    endfunction

    function automatic logic [15:0] header_crc(int first);
        logic [31:0] crc;
        int          k;
        crc = '0;
        for (k = first; k < burst_q.size(); k++) crc = crc32_byte(crc, burst_q[k].b);
        return crc[15:0];
    endfunction

    function automatic void queue_fixed(logic [7:0] flg);
        push_beat(MAGIC_ID1, 1'b1);
        push_beat(MAGIC_ID2, 1'b0);
        push_beat(METHOD_DEFLATE, 1'b0);
        push_beat(flg, 1'b0);
        repeat (6) push_beat(8'($urandom_range(0, 255)), 1'b0);
    endfunction

    // well-formed header with random content, sometimes a bad crc or trailing bytes
    function automatic void queue_header(logic [15:0] limit, logic no_restart);
        logic [7:0]  flg;
        logic [15:0] hcrc;
        int          first, n_extra, n_text, lim, t;
        first = burst_q.size();
        flg   = 8'($urandom_range(0, 255)) & FLAGS_DEFINED;
        queue_fixed(flg);
        if (flg[FLG_FEXTRA]) begin
            n_extra = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 6);
            push_beat(n_extra[7:0], 1'b0);
            push_beat(n_extra[15:8], 1'b0);
            repeat (n_extra) push_beat(8'($urandom_range(0, 255)), 1'b0);
        end
        lim = (limit < 16'd10) ? int'(limit) + 3 : 12;
        for (t = 0; t < 2; t++) begin
            if (flg[t == 0 ? FLG_FNAME : FLG_FCOMMENT]) begin
                n_text = $urandom_range(0, lim);
                repeat (n_text) push_beat(8'($urandom_range(1, 255)), 1'b0);
                push_beat(8'h00, 1'b0);
            end
        end
        if (flg[FLG_FHCRC]) begin
            hcrc = header_crc(first);
            if ($urandom_range(0, 7) == 0) hcrc = hcrc ^ 16'(1 << $urandom_range(0, 15));
            push_beat(hcrc[7:0], 1'b0);
            push_beat(hcrc[15:8], 1'b0);
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) push_beat(8'($urandom_range(0, 255)), 1'b0);
        if (no_restart) burst_q[first].restart = 1'b0;
    endfunction

    // header with a corrupted fixed byte, or cut short
    function automatic void queue_broken(logic [15:0] limit);
        int first, idx;
        first = burst_q.size();
        queue_header(limit, 1'b0);
        if ($urandom_range(0, 1) == 1) begin
            idx = first + $urandom_range(0, 3);
            if (idx == first + 3)
                burst_q[idx].b = burst_q[idx].b | (8'h20 << $urandom_range(0, 2));
            else
                burst_q[idx].b = 8'($urandom_range(0, 255));
        end else begin
            idx = first + $urandom_range(1, burst_q.size() - first - 1);
            while (burst_q.size() > idx) void'(burst_q.pop_back());
        end
    endfunction

    function automatic void queue_noise();
        repeat ($urandom_range(1, 8))
            push_beat(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    endfunction

    // all flags, correct crc, a byte after done, then ID1, ID2, method and flags each wrong
    function automatic void queue_directed();
        logic [15:0] hcrc;
        queue_fixed(FLAGS_DEFINED);
        push_beat(8'h01, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h41, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'h00, 1'b0);
        hcrc = header_crc(0);
        push_beat(hcrc[7:0], 1'b0);
        push_beat(hcrc[15:8], 1'b0);
        push_beat(8'h5A, 1'b0);
        push_beat(8'h00, 1'b1);
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(FLAG_RESERVED_MASK, 1'b0);
        push_beat(MAGIC_ID1, 1'b1);
    endfunction

    // one input beat, with random idle cycles ahead of it
    task automatic send_beat(logic [7:0] b, logic restart);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_hdr_byte <= b;
        s_restart  <= restart;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_burst();
        foreach (burst_q[i]) send_beat(burst_q[i].b, burst_q[i].restart);
    endtask

    // hold the sender until every expected result is back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // apb write, then read back
    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.max_len = data[15:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        psel    <= 1'b1;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[15:0] !== data[15:0]) begin
            sb.errors++;
            $error("max_field_length readback mismatch: expected %0d, got %0d",
                   data[15:0], prdata[15:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // random traffic under one idling profile and one field limit
    task automatic run_phase(int n_items, int s_idle, int m_stall, logic [15:0] limit);
        int sent, kind;
        bit paused;
        drain();
        reg_write(MAX_LEN_ADDR, {16'h0, limit});
        idle_pct  = s_idle;
        stall_pct = m_stall;
        sent      = 0;
        paused    = 0;
        while (sent < n_items) begin
            burst_q.delete();
            kind = $urandom_range(0, 99);
            if (kind < 70) queue_header(limit, kind < 5);
            else if (kind < 85) queue_broken(limit);
            else queue_noise();
            send_burst();
            sent += burst_q.size();
            if (!paused && sent >= n_items / 2) begin
                drain();
                paused = 1;
            end
        end
    endtask

    // main sequence
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        queue_directed();
        send_burst();
        run_phase(210, 0, 0, 16'd0);
        run_phase(210, 88, 0, 16'd3);
        run_phase(210, 0, 88, 16'($urandom_range(1, 12)));
        run_phase(210, 7, 7, MAX_FIELD_RESET);
        drain();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** gzip_header_parser_top: PASSED **");
        end else begin
            $display("** gzip_header_parser_top: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #12_000_000;
        $display("** gzip_header_parser_top: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/gzhp_pkg.sv
rtl/core/gzhp_crc32.sv
rtl/core/gzhp_parser.sv
rtl/core/gzip_header_parser_top.sv
dv/testbench.sv
